/* sv/pcum_pkg.sv */
// Package with shared types and constants of the per-context usage block.
package pcum_pkg;

    localparam int unsigned IdWidth   = 32;
    localparam int unsigned DataWidth = 64;

    typedef enum logic {
        t_kind_report = 1'b0,
        t_kind_round  = 1'b1
    } t_kind;

    typedef struct packed {
        logic                   kind;
        logic [IdWidth-1:0]     context_id;
        logic [DataWidth-1:0]   kernel_time;
        logic [DataWidth-1:0]   user_time;
        logic [DataWidth-1:0]   cycle_count;
    } t_in_item;

    typedef struct packed {
        logic [DataWidth-1:0]   latest_time_total;
        logic [DataWidth-1:0]   latest_cycle_total;
        logic [DataWidth-1:0]   median_time_total;
        logic [DataWidth-1:0]   median_cycle_total;
    } t_out_item;

endpackage

/* sv/pcum_in_if.sv */
// Valid-ready channel interface for input items.
interface pcum_in_if;
    logic                valid;
    logic                ready;
    pcum_pkg::t_in_item  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* sv/pcum_out_if.sv */
// Valid-ready channel interface for result items.
interface pcum_out_if;
    logic                 valid;
    logic                 ready;
    pcum_pkg::t_out_item  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* sv/per_context_usage_median.sv */
// Top level of the per-context usage accounting block with median-filtered totals.
// Input channel i_in carries items: a usage report (kind 0) or an end of round (kind 1).
// A report searches the context table one entry per cycle from entry 0 through the
// registered memory read port and then writes the entry. An unknown id is appended;
// with a full table the rest of the round's reports are dropped.
// An end of round sweeps all used entries, one memory read per cycle, summing the
// wrapping deltas of active entries whose previous values are both nonzero, copying
// current to previous and clearing the active marks. It then pushes both totals into
// the history windows and finds each median by compare counting over all window pairs.
// The block takes one item at a time; ready is low while an item is worked on.
// The result item goes out on o_out and is held until the receiver takes it; a new
// input item may be accepted meanwhile, but a following end of round waits for it.
// Reset clears the fill count, the active marks, the stop flag and the histories.
// A fresh entry has previous values of zero since appending writes them.
module per_context_usage_median #(
    parameter int unsigned TABLE_ENTRIES = 256,
    parameter int unsigned HISTORY_DEPTH = 5
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pcum_in_if.sink    i_in,
    pcum_out_if.source o_out
);
    localparam int unsigned DW = pcum_pkg::DataWidth;
    localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SEARCH, S_WRITE, S_SWEEP, S_MEDIAN, S_WAIT
    } t_state;

    logic [pcum_pkg::IdWidth-1:0] m_id    [TABLE_ENTRIES];
    logic [DW-1:0]                m_time  [TABLE_ENTRIES];
    logic [DW-1:0]                m_cyc   [TABLE_ENTRIES];
    logic [DW-1:0]                m_ptime [TABLE_ENTRIES];
    logic [DW-1:0]                m_pcyc  [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]     r_active;

    t_state  r_state;
    logic [CW-1:0] r_count;
    logic          r_stopped;
    logic [CW-1:0] r_ptr;
    logic [AW-1:0] r_raddr;
    logic          r_rvalid;
    logic [pcum_pkg::IdWidth-1:0] r_rd_id;
    logic [DW-1:0] r_rd_time, r_rd_cyc, r_rd_ptime, r_rd_pcyc;
    logic          r_rd_act;
    pcum_pkg::t_in_item r_item;
    logic [DW-1:0] r_tsum, r_csum;
    logic [HISTORY_DEPTH*DW-1:0] r_thist, r_chist;
    logic          r_med_start;
    logic          r_out_valid;
    pcum_pkg::t_out_item r_out;

    logic          w_tdone, w_cdone;
    logic [DW-1:0] w_tmed, w_cmed;
    logic [DW-1:0] w_new_time;
    logic          w_accept;

    assign w_new_time = r_item.kernel_time + r_item.user_time;
    assign w_accept   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE) &&
                        !(r_out_valid && i_in.payload.kind == pcum_pkg::t_kind_round);
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // Memory read port, registered.
    always_ff @(posedge i_clk) begin
        r_rd_id    <= m_id[AW'(r_ptr)];
        r_rd_time  <= m_time[AW'(r_ptr)];
        r_rd_cyc   <= m_cyc[AW'(r_ptr)];
        r_rd_ptime <= m_ptime[AW'(r_ptr)];
        r_rd_pcyc  <= m_pcyc[AW'(r_ptr)];
        r_rd_act   <= r_active[AW'(r_ptr)];
    end

    pcum_median #(.DEPTH(HISTORY_DEPTH)) u_tmed (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_med_start),
        .i_window(r_thist), .o_done(w_tdone), .o_median(w_tmed)
    );
    pcum_median #(.DEPTH(HISTORY_DEPTH)) u_cmed (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_med_start),
        .i_window(r_chist), .o_done(w_cdone), .o_median(w_cmed)
    );

    always_ff @(posedge i_clk) begin
        r_med_start <= 1'b0;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_stopped   <= 1'b0;
            r_active    <= '0;
            r_thist     <= '0;
            r_chist     <= '0;
            r_out_valid <= 1'b0;
            r_rvalid    <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_item   <= i_in.payload;
                        r_ptr    <= '0;
                        r_raddr  <= '0;
                        r_rvalid <= 1'b0;
                        r_tsum   <= '0;
                        r_csum   <= '0;
                        if (i_in.payload.kind == pcum_pkg::t_kind_round) begin
                            r_state <= S_SWEEP;
                        end else if (!r_stopped) begin
                            r_state <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH: begin
                    // While r_rvalid is high the read port holds entry r_ptr - 1.
                    if (r_rvalid && r_rd_id == r_item.context_id) begin
                        r_raddr <= AW'(r_ptr - 1'b1);
                        r_state <= S_WRITE;
                        r_rvalid <= 1'b0;
                    end else if (r_ptr == r_count) begin
                        if (r_count == CW'(TABLE_ENTRIES)) begin
                            r_stopped <= 1'b1;
                            r_state   <= S_IDLE;
                        end else begin
                            r_raddr  <= AW'(r_count);
                            m_ptime[AW'(r_count)] <= '0;
                            m_pcyc[AW'(r_count)]  <= '0;
                            r_count  <= r_count + 1'b1;
                            r_state  <= S_WRITE;
                        end
                        r_rvalid <= 1'b0;
                    end else begin
                        r_ptr    <= r_ptr + 1'b1;
                        r_rvalid <= 1'b1;
                    end
                end
                S_WRITE: begin
                    m_id[r_raddr]     <= r_item.context_id;
                    m_time[r_raddr]   <= w_new_time;
                    m_cyc[r_raddr]    <= r_item.cycle_count;
                    r_active[r_raddr] <= 1'b1;
                    r_state           <= S_IDLE;
                end
                S_SWEEP: begin
                    if (r_rvalid && r_rd_act) begin
                        if (r_rd_ptime != '0 && r_rd_pcyc != '0) begin
                            r_tsum <= r_tsum + (r_rd_time - r_rd_ptime);
                            r_csum <= r_csum + (r_rd_cyc - r_rd_pcyc);
                        end
                        m_ptime[AW'(r_ptr - 1'b1)]  <= r_rd_time;
                        m_pcyc[AW'(r_ptr - 1'b1)]   <= r_rd_cyc;
                        r_active[AW'(r_ptr - 1'b1)] <= 1'b0;
                    end
                    if (r_ptr == r_count) begin
                        r_rvalid <= 1'b0;
                        if (!r_rvalid || r_count == '0) begin
                            r_stopped <= 1'b0;
                            r_state   <= S_MEDIAN;
                        end
                    end else begin
                        r_ptr    <= r_ptr + 1'b1;
                        r_rvalid <= 1'b1;
                    end
                end
                S_MEDIAN: begin
                    r_thist <= {r_tsum, r_thist[HISTORY_DEPTH*DW-1:DW]};
                    r_chist <= {r_csum, r_chist[HISTORY_DEPTH*DW-1:DW]};
                    r_med_start  <= 1'b1;
                    r_state      <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_tdone && w_cdone) begin
                        r_out.latest_time_total  <= r_tsum;
                        r_out.latest_cycle_total <= r_csum;
                        r_out.median_time_total  <= w_tmed;
                        r_out.median_cycle_total <= w_cmed;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* sv/pcum_median.sv */
// Sequential median of a history window, one compare-count step per cycle.
module pcum_median #(
    parameter int unsigned DEPTH = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [DEPTH*pcum_pkg::DataWidth-1:0] i_window,
    output logic                              o_done,
    output logic [pcum_pkg::DataWidth-1:0]    o_median
);
    localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned Mid = DEPTH / 2;

    logic          r_busy;
    logic [IW-1:0] r_i;
    logic [IW-1:0] r_j;
    logic [CW-1:0] r_less;
    logic [CW-1:0] r_leq;
    logic          r_found;
    logic [pcum_pkg::DataWidth-1:0] r_median;
    logic          r_done;

    logic [pcum_pkg::DataWidth-1:0] w_a;
    logic [pcum_pkg::DataWidth-1:0] w_b;
    logic [CW-1:0] n_less;
    logic [CW-1:0] n_leq;

    assign w_a = i_window[r_i*pcum_pkg::DataWidth +: pcum_pkg::DataWidth];
    assign w_b = i_window[r_j*pcum_pkg::DataWidth +: pcum_pkg::DataWidth];
    assign n_less = r_less + CW'(w_b < w_a);
    assign n_leq  = r_leq + CW'(w_b <= w_a);

    // Element i is the median when fewer than Mid+1 are below it and at least Mid+1 are at or below.
    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_i     <= '0;
            r_j     <= '0;
            r_less  <= '0;
            r_leq   <= '0;
            r_found <= 1'b0;
        end else if (r_busy) begin
            if (r_j == IW'(DEPTH - 1)) begin
                r_j    <= '0;
                r_less <= '0;
                r_leq  <= '0;
                if (!r_found && n_less <= CW'(Mid) && n_leq > CW'(Mid)) begin
                    r_found  <= 1'b1;
                    r_median <= w_a;
                end
                if (r_i == IW'(DEPTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end else begin
                r_j    <= r_j + 1'b1;
                r_less <= n_less;
                r_leq  <= n_leq;
            end
        end
    end

    assign o_done   = r_done;
    assign o_median = r_median;
endmodule

/* sv/pcum_checker.sv */
// Port-level assertions for the per-context usage block and their bind.
module pcum_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic i_ready,
    input logic i_kind,
    input logic o_valid,
    input logic o_ready,
    input logic [4*pcum_pkg::DataWidth-1:0] o_payload
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ready |=> o_valid && $stable(o_payload))
        else $error("result item changed while stalled");

    a_busy_after_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && i_kind |=> !i_ready)
        else $error("ready high right after an accepted end of round");

    a_no_round_while_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_valid && i_kind |-> !i_ready)
        else $error("end of round accepted while a result waits");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
endmodule

bind per_context_usage_median pcum_checker u_pcum_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_valid(i_in.valid), .i_ready(i_in.ready), .i_kind(i_in.payload.kind),
    .o_valid(o_out.valid), .o_ready(o_out.ready), .o_payload(o_out.payload)
);

/* tb/sv/tb_top.sv */
// Testbench for the per-context usage block: predicts round totals and medians and checks them.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumEntries = 256;
    localparam int HistDepth  = 5;
    localparam int WatchLimit = 20000;

    logic i_clk;
    logic i_rst_n;
    pcum_in_if  in_ch ();
    pcum_out_if out_ch ();

    per_context_usage_median #(.TABLE_ENTRIES(NumEntries), .HISTORY_DEPTH(HistDepth)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    logic [31:0] tbl_id [NumEntries];
    logic        tbl_act [NumEntries];
    logic [63:0] tbl_time [NumEntries];
    logic [63:0] tbl_ptime [NumEntries];
    logic [63:0] tbl_cyc [NumEntries];
    logic [63:0] tbl_pcyc [NumEntries];
    int          tbl_fill;
    bit          tbl_stopped;
    logic [63:0] hist_time [HistDepth];
    logic [63:0] hist_cyc [HistDepth];
    pcum_pkg::t_out_item totals_q [$];
    int          fails;
    int          idle_cycles;
    bit          rx_stall_long;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] window_median(ref logic [63:0] win [HistDepth],
                                                   input logic [63:0] v);
        logic [63:0] s [HistDepth];
        logic [63:0] t;
        for (int i = 0; i < HistDepth - 1; i++) win[i] = win[i+1];
        win[HistDepth-1] = v;
        s = win;
        for (int i = 0; i < HistDepth; i++)
            for (int j = 0; j < HistDepth - 1 - i; j++)
                if (s[j] > s[j+1]) begin
                    t = s[j]; s[j] = s[j+1]; s[j+1] = t;
                end
        return s[HistDepth/2];
    endfunction

    task automatic account_item(input pcum_pkg::t_in_item it);
        int idx;
        logic [63:0] ts, cs;
        pcum_pkg::t_out_item r;
        if (pcum_pkg::t_kind'(it.kind) == pcum_pkg::t_kind_report) begin
            if (tbl_stopped) return;
            idx = -1;
            for (int i = 0; i < tbl_fill; i++)
                if (tbl_id[i] == it.context_id) begin
                    idx = i;
                    break;
                end
            if (idx < 0) begin
                if (tbl_fill >= NumEntries) begin
                    tbl_stopped = 1'b1;
                    return;
                end
                idx = tbl_fill++;
            end
            tbl_id[idx]   = it.context_id;
            tbl_time[idx] = it.kernel_time + it.user_time;
            tbl_cyc[idx]  = it.cycle_count;
            tbl_act[idx]  = 1'b1;
        end else begin
            ts = '0;
            cs = '0;
            for (int i = 0; i < tbl_fill; i++)
                if (tbl_act[i]) begin
                    if (tbl_ptime[i] != 0 && tbl_pcyc[i] != 0) begin
                        ts += tbl_time[i] - tbl_ptime[i];
                        cs += tbl_cyc[i] - tbl_pcyc[i];
                    end
                    tbl_ptime[i] = tbl_time[i];
                    tbl_pcyc[i]  = tbl_cyc[i];
                    tbl_act[i]   = 1'b0;
                end
            tbl_stopped = 1'b0;
            r.latest_time_total  = ts;
            r.latest_cycle_total = cs;
            r.median_time_total  = window_median(hist_time, ts);
            r.median_cycle_total = window_median(hist_cyc, cs);
            totals_q.push_back(r);
        end
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    task automatic send_item(input pcum_pkg::t_in_item it, input bit no_gap = 0);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        account_item(it);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic pcum_pkg::t_in_item make_report(input logic [31:0] id,
                                                       input logic [63:0] k,
                                                       input logic [63:0] u,
                                                       input logic [63:0] c);
        pcum_pkg::t_in_item it;
        it.kind = pcum_pkg::t_kind_report;
        it.context_id = id;
        it.kernel_time = k;
        it.user_time = u;
        it.cycle_count = c;
        return it;
    endfunction

    function automatic pcum_pkg::t_in_item make_round();
        pcum_pkg::t_in_item it;
        it = make_report($urandom(), rnd64(), rnd64(), rnd64());
        it.kind = pcum_pkg::t_kind_round;
        return it;
    endfunction

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (totals_q.size() != 0);
    endtask

    task automatic test_directed();
        send_item(make_round());
        send_item(make_report(32'h0, 64'h0, 64'h0, 64'h0));
        send_item(make_report(32'hFFFF_FFFF, '1, '1, '1));
        send_item(make_report(32'h1, 64'h10, 64'h5, 64'h100));
        send_item(make_round());
        send_item(make_report(32'h1, 64'h20, 64'h5, 64'h300));
        send_item(make_report(32'hFFFF_FFFF, 64'h1, 64'h0, 64'h2));
        send_item(make_report(32'h0, 64'h7, 64'h0, 64'h9));
        send_item(make_round());
        send_item(make_report(32'h1, 64'h0, 64'h1, 64'h0));
        send_item(make_report(32'h0, '1, 64'h0, '1));
        send_item(make_round());
        send_item(make_round());
        send_item(make_round());
        send_item(make_round());
        wait_drained();
    endtask

    task automatic test_table_full();
        for (int i = 0; i < NumEntries + 3; i++)
            send_item(make_report(32'h1000 + i, rnd64(), rnd64(), rnd64()), i % 7 != 0);
        send_item(make_report(32'h1, rnd64(), rnd64(), rnd64()));
        send_item(make_round());
        for (int i = 0; i < 40; i++)
            send_item(make_report(32'h1000 + $urandom_range(0, 300), rnd64(), rnd64(), rnd64()),
                      1);
        send_item(make_round());
        wait_drained();
    endtask

    task automatic test_random();
        int rounds;
        int per;
        logic [31:0] ids [8];
        for (int i = 0; i < 8; i++) ids[i] = $urandom();
        rounds = 0;
        for (int n = 0; n < 1100;) begin
            per = $urandom_range(0, 10);
            for (int j = 0; j < per; j++) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(make_report($urandom(), rnd64(), rnd64(), rnd64()));
                else if ($urandom_range(0, 4) == 0)
                    send_item(make_report(ids[$urandom_range(0, 7)],
                                          '1 - 64'($urandom_range(0, 3)),
                                          64'($urandom_range(0, 3)),
                                          64'($urandom_range(0, 3))));
                else
                    send_item(make_report(ids[$urandom_range(0, 7)], rnd64(), rnd64(), rnd64()));
                n++;
            end
            send_item(make_round());
            n++;
            rounds++;
            if (rounds == 30) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        fails = 0;
        tbl_fill = 0;
        tbl_stopped = 0;
        for (int i = 0; i < NumEntries; i++) begin
            tbl_act[i] = 0; tbl_ptime[i] = 0; tbl_pcyc[i] = 0;
        end
        for (int i = 0; i < HistDepth; i++) begin
            hist_time[i] = 0; hist_cyc[i] = 0;
        end
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_table_full();
        test_random();
        repeat (NumEntries + HistDepth * HistDepth + 20) @(posedge i_clk);
        if (fails == 0 && totals_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        int stall;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall = gap_len();
            end
        end
    end

    always @(posedge i_clk) begin
        pcum_pkg::t_out_item exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (totals_q.size() == 0) begin
                $error("unexpected result item");
                fails++;
            end else begin
                exp_r = totals_q.pop_front();
                if (out_ch.payload.latest_time_total !== exp_r.latest_time_total) begin
                    $error("latest_time_total exp %h got %h", exp_r.latest_time_total,
                           out_ch.payload.latest_time_total);
                    fails++;
                end
                if (out_ch.payload.latest_cycle_total !== exp_r.latest_cycle_total) begin
                    $error("latest_cycle_total exp %h got %h", exp_r.latest_cycle_total,
                           out_ch.payload.latest_cycle_total);
                    fails++;
                end
                if (out_ch.payload.median_time_total !== exp_r.median_time_total) begin
                    $error("median_time_total exp %h got %h", exp_r.median_time_total,
                           out_ch.payload.median_time_total);
                    fails++;
                end
                if (out_ch.payload.median_cycle_total !== exp_r.median_cycle_total) begin
                    $error("median_cycle_total exp %h got %h", exp_r.median_cycle_total,
                           out_ch.payload.median_cycle_total);
                    fails++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WatchLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end
endmodule
